// ----- hdl/u8sd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder: result status
// codes, the work item passed from the byte front end to the result back end,
// and the byte / code point limits used by classification and checking.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int CP_WIDTH           = 21;
   localparam int SHOWN_COUNT_WIDTH  = 32;
   localparam int COUNT_BITS_DEFAULT = 32;

   // Byte classes
   localparam logic [7:0] CONT_MIN   = 8'h80;  // first continuation byte
   localparam logic [7:0] LEAD_BASE  = 8'hC0;  // first lead-byte pattern
   localparam logic [7:0] LEAD_MIN   = 8'hC2;  // smallest non-overlong lead
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT = 8'hF5;  // leads from here up are bad

   // Code point limits
   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] TWO_BYTE_MIN   = 21'h000080;
   localparam logic [CP_WIDTH-1:0] THREE_BYTE_MIN = 21'h000800;
   localparam logic [CP_WIDTH-1:0] SURR_LO        = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI        = 21'h00E000;
   localparam logic [CP_WIDTH-1:0] FOUR_BYTE_MIN  = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_LIMIT       = 21'h110000;

   typedef enum logic [1:0] {
      ST_VALID      = 2'd0,
      ST_INVALID    = 2'd1,
      ST_INCOMPLETE = 2'd2,
      ST_ENDED      = 2'd3
   } status_type;

   // What the back end does with a work item
   typedef enum logic [1:0] {
      OP_EMIT = 2'd0,  // literal code point and status as given
      OP_BAD  = 2'd1,  // invalid result, value set by replace mode
      OP_SEQ  = 2'd2   // multi-byte sequence to assemble and check
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
      logic [7:0] lit;    // literal code point (ASCII or zero)
      logic [7:0] lead;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] need;   // continuation bytes of the sequence
      logic       last;
   } work_type;

endpackage : u8sd_pkg
`default_nettype wire

// ----- hdl/utf8_stream_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream decoder: one byte per transaction in, at most one code
// point result per byte out, with a saturating count of decoded characters.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless rsp_tready back-pressure fills the
//   two-entry work queue that joins the front end and the back end.
// Path: the edge that accepts the final byte writes the queue, then the
//   back-end output register loads the result onto rsp_*.
// Reset: synchronous, active high; clears sequence state, queue, count and
//   replace_mode; no clearing pass is needed.
module utf8_stream_decoder_unit #(
   parameter int COUNT_BITS = u8sd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,  // replace_mode
   // byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tlast,    // last_byte
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,    // [20:0] code_point, [52:21] char_count
   output logic [1:0]       rsp_tuser,    // [1:0] status
   output logic             rsp_tlast     // end_flag
);
   import u8sd_pkg::*;

   logic                         replace_ff;
   logic                         q_full;
   logic                         q_push;
   work_type                     push_item;
   logic                         q_valid;
   logic                         q_pop;
   work_type                     head_item;
   logic [CP_WIDTH-1:0]          code_point;
   logic [SHOWN_COUNT_WIDTH-1:0] char_count;

   // Replace-mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         replace_ff <= 1'b0;
      end else if (csr_wr_en) begin
         replace_ff <= csr_wr_data;
      end
   end

   u8sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   u8sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (head_item)
   );

   u8sd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .replace_mode   (replace_ff),
      .q_valid        (q_valid),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_code_point (code_point),
      .rsp_status     (rsp_tuser),
      .rsp_end        (rsp_tlast),
      .rsp_count      (char_count)
   );

   assign rsp_tdata = {3'b000, char_count, code_point};

endmodule : utf8_stream_decoder_unit
`default_nettype wire

// ----- hdl/u8sd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_front
// Byte front end: accepts one byte per cycle unless q_full, tracks the open
// sequence and the string-ended state, and queues one work item per result.
// ----------------------------------------------------------------------------
module u8sd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              q_full,
   output logic                   q_push,
   output u8sd_pkg::work_type     q_item
);
   import u8sd_pkg::*;

   logic       accept;
   logic       push;
   work_type   item;

   logic [1:0] need_ff, need_in;
   logic [1:0] held_ff, held_in;
   logic       done_ff, done_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] seq0_ff, seq0_in;
   logic [7:0] seq1_ff, seq1_in;
   logic [1:0] held_next;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign held_next  = held_ff + 2'd1;

   // Classify the byte and update sequence state
   always_comb begin
      push        = 1'b0;
      item.op     = OP_EMIT;
      item.status = ST_VALID;
      item.lit    = '0;
      item.lead   = lead_ff;
      item.b0     = (held_ff == 2'd0) ? req_tdata : seq0_ff;
      item.b1     = (held_ff == 2'd1) ? req_tdata : seq1_ff;
      item.b2     = req_tdata;
      item.need   = need_ff;
      item.last   = req_tlast;
      need_in     = need_ff;
      held_in     = held_ff;
      done_in     = done_ff;
      lead_in     = lead_ff;
      seq0_in     = seq0_ff;
      seq1_in     = seq1_ff;
      if (accept) begin
         if (done_ff) begin
            // swallow bytes until the buffer ends
            if (req_tlast) begin
               done_in = 1'b0;
            end
         end else if (need_ff != 2'd0) begin
            if (held_next == need_ff) begin
               push    = 1'b1;
               item.op = OP_SEQ;
               need_in = 2'd0;
               held_in = 2'd0;
            end else if (req_tlast) begin
               push        = 1'b1;
               item.status = ST_INCOMPLETE;
               item.last   = 1'b1;
               need_in     = 2'd0;
               held_in     = 2'd0;
            end else begin
               if (held_ff == 2'd0) begin
                  seq0_in = req_tdata;
               end else begin
                  seq1_in = req_tdata;
               end
               held_in = held_next;
            end
         end else if (req_tdata == 8'd0) begin
            push        = 1'b1;
            item.status = ST_ENDED;
            item.last   = 1'b1;
            done_in     = !req_tlast;
         end else if (req_tdata < CONT_MIN) begin
            push     = 1'b1;
            item.lit = req_tdata;
         end else if (req_tdata < LEAD_BASE) begin
            // stray continuation byte, reported only at buffer end
            push    = req_tlast;
            item.op = OP_BAD;
         end else if (req_tdata < LEAD_MIN || req_tdata >= LEAD_LIMIT) begin
            push    = 1'b1;
            item.op = OP_BAD;
         end else if (req_tlast) begin
            push        = 1'b1;
            item.status = ST_INCOMPLETE;
         end else begin
            lead_in = req_tdata;
            held_in = 2'd0;
            if (req_tdata < LEAD3_MIN) begin
               need_in = 2'd1;
            end else if (req_tdata < LEAD4_MIN) begin
               need_in = 2'd2;
            end else begin
               need_in = 2'd3;
            end
         end
      end
   end

   assign q_push = push;
   assign q_item = item;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= '0;
         held_ff <= '0;
         done_ff <= 1'b0;
         lead_ff <= '0;
      end else begin
         need_ff <= need_in;
         held_ff <= held_in;
         done_ff <= done_in;
         lead_ff <= lead_in;
      end
   end

   // Held continuation bytes
   always_ff @(posedge clock) begin
      seq0_ff <= seq0_in;
      seq1_ff <= seq1_in;
   end

`ifndef SYNTHESIS
   // Bytes held always stay below the bytes the lead announced
   a_held_below_need: assert property (@(posedge clock) disable iff (reset)
      (need_ff != 2'd0) |-> (held_ff < need_ff))
      else $error("held byte count reached sequence length");
`endif

endmodule : u8sd_front
`default_nettype wire

// ----- hdl/u8sd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_queue
// Two-entry work queue between the front end and the back end.
// ----------------------------------------------------------------------------
module u8sd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8sd_pkg::work_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output u8sd_pkg::work_type      head_item
);
   import u8sd_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign valid     = (count_ff != 2'd0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full work queue");
`endif

endmodule : u8sd_queue
`default_nettype wire

// ----- hdl/u8sd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_back
// Result back end: assembles and checks sequences, picks the error value,
// keeps the saturating character count and holds the output register.
// ----------------------------------------------------------------------------
module u8sd_back #(
   parameter int COUNT_BITS = u8sd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                replace_mode,
   input  wire logic                q_valid,
   input  wire u8sd_pkg::work_type  q_item,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [u8sd_pkg::CP_WIDTH-1:0]          rsp_code_point,
   output logic [1:0]                             rsp_status,
   output logic                                   rsp_end,
   output logic [u8sd_pkg::SHOWN_COUNT_WIDTH-1:0] rsp_count
);
   import u8sd_pkg::*;

   logic [CP_WIDTH-1:0]   asm_cp;
   logic                  cont_ok;
   logic                  range_ok;
   logic [CP_WIDTH-1:0]   bad_cp;
   logic [CP_WIDTH-1:0]   res_cp;
   status_type            res_status;

   logic                  valid_ff;
   logic [CP_WIDTH-1:0]   cp_ff;
   status_type            status_ff;
   logic                  end_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign q_pop  = q_valid && (!valid_ff || rsp_tready);
   assign bad_cp = replace_mode ? REPLACEMENT_CP : '0;

   // Assemble the code point and check continuation bits
   always_comb begin
      case (q_item.need)
         2'd1: begin
            asm_cp  = {10'd0, q_item.lead[4:0], q_item.b0[5:0]};
            cont_ok = (q_item.b0[7:6] == 2'b10);
         end
         2'd2: begin
            asm_cp  = {5'd0, q_item.lead[3:0], q_item.b0[5:0], q_item.b1[5:0]};
            cont_ok = (q_item.b0[7:6] == 2'b10) && (q_item.b1[7:6] == 2'b10);
         end
         default: begin
            asm_cp  = {q_item.lead[2:0], q_item.b0[5:0], q_item.b1[5:0],
                       q_item.b2[5:0]};
            cont_ok = (q_item.b0[7:6] == 2'b10) && (q_item.b1[7:6] == 2'b10)
                      && (q_item.b2[7:6] == 2'b10);
         end
      endcase
   end

   // Overlong, surrogate and upper range checks
   always_comb begin
      case (q_item.need)
         2'd1:    range_ok = (asm_cp >= TWO_BYTE_MIN);
         2'd2:    range_ok = (asm_cp >= THREE_BYTE_MIN) &&
                             !((asm_cp >= SURR_LO) && (asm_cp < SURR_HI));
         default: range_ok = (asm_cp >= FOUR_BYTE_MIN) && (asm_cp < CP_LIMIT);
      endcase
   end

   // Result selection
   always_comb begin
      unique case (q_item.op)
         OP_EMIT: begin
            res_cp     = {{(CP_WIDTH-8){1'b0}}, q_item.lit};
            res_status = q_item.status;
         end
         OP_SEQ: begin
            if (cont_ok && range_ok) begin
               res_cp     = asm_cp;
               res_status = ST_VALID;
            end else begin
               res_cp     = bad_cp;
               res_status = ST_INVALID;
            end
         end
         default: begin
            res_cp     = bad_cp;
            res_status = ST_INVALID;
         end
      endcase
   end

   // Saturating count of nonzero results
   always_comb begin
      count_in = count_ff;
      if (q_pop && (res_cp != '0) && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (q_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cp_ff     <= res_cp;
         status_ff <= res_status;
         end_ff    <= q_item.last;
      end
   end

   assign rsp_tvalid     = valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_status     = status_ff;
   assign rsp_end        = end_ff;

   generate
      if (COUNT_BITS >= SHOWN_COUNT_WIDTH) begin : g_count_wide
         assign rsp_count = count_ff[SHOWN_COUNT_WIDTH-1:0];
      end else begin : g_count_narrow
         assign rsp_count = {{(SHOWN_COUNT_WIDTH-COUNT_BITS){1'b0}}, count_ff};
      end
   endgenerate

`ifndef SYNTHESIS
   a_valid_not_surrogate: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff == ST_VALID)) |->
         (cp_ff < SURR_LO || cp_ff >= SURR_HI) && (cp_ff < CP_LIMIT))
      else $error("valid result outside scalar range");
   a_no_value_on_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff == ST_INCOMPLETE || status_ff == ST_ENDED)) |->
         (cp_ff == '0) && end_ff)
      else $error("incomplete or ended result carries a value");
`endif

endmodule : u8sd_back
`default_nettype wire
